// ===== hdl/fisr_pkg.sv =====
// ============================================================================
// fisr_pkg
// Shared constants and helper functions for the fast inverse square root
// pipeline: binary32 constants, a leading-zero counter and a rounding packer.
// ============================================================================
package fisr_pkg;

    localparam int TAG_W = 32;

    localparam logic [31:0] MAGIC_GUESS  = 32'h5F3759DF;
    localparam logic [31:0] FP_HALF      = 32'h3F000000;
    localparam logic [31:0] FP_THREE_HLF = 32'h3FC00000;
    localparam logic [31:0] CANON_QNAN   = 32'h7FC00000;
    localparam logic [7:0]  EXP_ALL_ONES = 8'hFF;

    // Number of leading zeros of a 51-bit word (51 when the word is zero).
    function automatic logic [5:0] lzc51(input logic [50:0] v);
        logic [5:0] n;
        n = 6'd51;
        for (int i = 0; i < 51; i++)
        begin
            if (v[i])
            begin
                n = 6'(50 - i);
            end
        end
        return n;
    endfunction

    // Round to nearest even and pack. The exponent field is 0 for a
    // subnormal; a carry out of the fraction moves into the exponent.
    function automatic logic [31:0] round_pack(
        input logic              sign,
        input logic signed [9:0] expf,
        input logic [23:0]       keep,
        input logic              guard,
        input logic              sticky
    );
        logic        up;
        logic [30:0] mag;
        up  = guard & (sticky | keep[0]);
        mag = {expf[7:0], keep[22:0]} + 31'(up);
        if (expf >= 10'sd255)
        begin
            return {sign, EXP_ALL_ONES, 23'd0};
        end
        return {sign, mag};
    endfunction

endpackage

// ===== hdl/fisr_fmul.sv =====
// ============================================================================
// fisr_fmul
// Three-stage binary32 multiplier, round to nearest even, with subnormals.
// A tag word travels alongside each operand pair.
// ============================================================================
module fisr_fmul
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_stall,
    input  logic [31:0]                a,
    input  logic [31:0]                b,
    input  logic [fisr_pkg::TAG_W-1:0] in_tag,
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic [31:0]                out_bits,
    output logic [fisr_pkg::TAG_W-1:0] out_tag
);

    logic en1;
    logic en2;
    logic en3;

    // Stage 1 registers: product and flags.
    logic                       v1_reg;
    logic                       sign1_reg;
    logic                       nan1_reg;
    logic                       inf1_reg;
    logic                       zero1_reg;
    logic signed [9:0]          exp1_reg;
    logic [47:0]                prod1_reg;
    logic [fisr_pkg::TAG_W-1:0] tag1_reg;

    // Stage 2 registers: normalized mantissa.
    logic                       v2_reg;
    logic                       sign2_reg;
    logic                       nan2_reg;
    logic                       inf2_reg;
    logic                       zero2_reg;
    logic signed [9:0]          expf2_reg;
    logic [47:0]                man2_reg;
    logic                       st2_reg;
    logic [fisr_pkg::TAG_W-1:0] tag2_reg;

    // Stage 3 registers: packed result.
    logic                       v3_reg;
    logic [31:0]                res3_reg;
    logic [fisr_pkg::TAG_W-1:0] tag3_reg;

    logic                       a_zexp;
    logic                       b_zexp;
    logic                       a_inf;
    logic                       b_inf;
    logic                       a_nan;
    logic                       b_nan;
    logic                       a_zero;
    logic                       b_zero;
    logic [7:0]                 ea_eff;
    logic [7:0]                 eb_eff;
    logic                       nan1_next;
    logic                       inf1_next;
    logic                       zero1_next;
    logic signed [9:0]          exp1_next;
    logic [47:0]                prod1_next;

    logic [5:0]                 lz;
    logic signed [9:0]          en;
    logic [6:0]                 rs;
    logic [47:0]                man2_next;
    logic signed [9:0]          expf2_next;
    logic                       st2_next;

    logic [31:0]                res3_next;

    // A stage moves when it is empty or the stage after it moves.
    assign en3      = !(v3_reg && out_stall);
    assign en2      = !(v2_reg && !en3);
    assign en1      = !(v1_reg && !en2);
    assign in_stall = !en1;

    always_comb
    begin
        a_zexp     = (a[30:23] == 8'd0);
        b_zexp     = (b[30:23] == 8'd0);
        a_inf      = (a[30:23] == fisr_pkg::EXP_ALL_ONES) && (a[22:0] == 23'd0);
        b_inf      = (b[30:23] == fisr_pkg::EXP_ALL_ONES) && (b[22:0] == 23'd0);
        a_nan      = (a[30:23] == fisr_pkg::EXP_ALL_ONES) && (a[22:0] != 23'd0);
        b_nan      = (b[30:23] == fisr_pkg::EXP_ALL_ONES) && (b[22:0] != 23'd0);
        a_zero     = (a[30:0] == 31'd0);
        b_zero     = (b[30:0] == 31'd0);
        ea_eff     = a_zexp ? 8'd1 : a[30:23];
        eb_eff     = b_zexp ? 8'd1 : b[30:23];
        nan1_next  = a_nan || b_nan || (a_inf && b_zero) || (b_inf && a_zero);
        inf1_next  = a_inf || b_inf;
        zero1_next = a_zero || b_zero;
        exp1_next  = $signed({2'b00, ea_eff}) + $signed({2'b00, eb_eff}) - 10'sd127;
        prod1_next = {!a_zexp, a[22:0]} * {!b_zexp, b[22:0]};
    end

    // Normalize: bit 47 of the product weighs 2^(exp+1-127) before shifting.
    always_comb
    begin
        lz         = fisr_pkg::lzc51({prod1_reg, 3'b000});
        en         = exp1_reg + 10'sd1 - $signed({4'b0000, lz});
        rs         = 7'(-exp1_reg);
        st2_next   = 1'b0;
        expf2_next = 10'sd0;
        if (en > 10'sd0)
        begin
            man2_next  = prod1_reg << lz;
            expf2_next = en;
        end
        else if (exp1_reg >= 10'sd0)
        begin
            man2_next = prod1_reg << exp1_reg[5:0];
        end
        else
        begin
            man2_next = prod1_reg >> rs;
            st2_next  = ((man2_next << rs) != prod1_reg);
        end
    end

    always_comb
    begin
        if (nan2_reg)
        begin
            res3_next = fisr_pkg::CANON_QNAN;
        end
        else if (inf2_reg)
        begin
            res3_next = {sign2_reg, fisr_pkg::EXP_ALL_ONES, 23'd0};
        end
        else if (zero2_reg)
        begin
            res3_next = {sign2_reg, 31'd0};
        end
        else
        begin
            res3_next = fisr_pkg::round_pack(sign2_reg, expf2_reg, man2_reg[47:24],
                                             man2_reg[23],
                                             (man2_reg[22:0] != 23'd0) || st2_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            if (en1)
            begin
                v1_reg <= in_valid;
            end
            if (en2)
            begin
                v2_reg <= v1_reg;
            end
            if (en3)
            begin
                v3_reg <= v2_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            sign1_reg <= a[31] ^ b[31];
            nan1_reg  <= nan1_next;
            inf1_reg  <= inf1_next;
            zero1_reg <= zero1_next;
            exp1_reg  <= exp1_next;
            prod1_reg <= prod1_next;
            tag1_reg  <= in_tag;
        end
        if (en2)
        begin
            sign2_reg <= sign1_reg;
            nan2_reg  <= nan1_reg;
            inf2_reg  <= inf1_reg;
            zero2_reg <= zero1_reg;
            expf2_reg <= expf2_next;
            man2_reg  <= man2_next;
            st2_reg   <= st2_next;
            tag2_reg  <= tag1_reg;
        end
        if (en3)
        begin
            res3_reg <= res3_next;
            tag3_reg <= tag2_reg;
        end
    end

    assign out_valid = v3_reg;
    assign out_bits  = res3_reg;
    assign out_tag   = tag3_reg;

endmodule

// ===== hdl/fisr_fadd.sv =====
// ============================================================================
// fisr_fadd
// Three-stage binary32 adder, round to nearest even, with subnormals.
// Stages: align, add with leading-zero count, normalize and round.
// ============================================================================
module fisr_fadd
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_stall,
    input  logic [31:0]                a,
    input  logic [31:0]                b,
    input  logic [fisr_pkg::TAG_W-1:0] in_tag,
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic [31:0]                out_bits,
    output logic [fisr_pkg::TAG_W-1:0] out_tag
);

    logic en1;
    logic en2;
    logic en3;

    logic                       v1_reg;
    logic                       sign1_reg;
    logic                       sub1_reg;
    logic                       nan1_reg;
    logic                       inf1_reg;
    logic                       isign1_reg;
    logic [7:0]                 eb1_reg;
    logic [49:0]                big1_reg;
    logic [49:0]                sml1_reg;
    logic [fisr_pkg::TAG_W-1:0] tag1_reg;

    logic                       v2_reg;
    logic                       sign2_reg;
    logic                       zsign2_reg;
    logic                       nan2_reg;
    logic                       inf2_reg;
    logic                       isign2_reg;
    logic [7:0]                 eb2_reg;
    logic [50:0]                sum2_reg;
    logic [5:0]                 lz2_reg;
    logic [fisr_pkg::TAG_W-1:0] tag2_reg;

    logic                       v3_reg;
    logic [31:0]                res3_reg;
    logic [fisr_pkg::TAG_W-1:0] tag3_reg;

    logic                       a_inf;
    logic                       b_inf;
    logic                       a_nan;
    logic                       b_nan;
    logic                       swap;
    logic [31:0]                op_big;
    logic [31:0]                op_sml;
    logic [7:0]                 eb_eff;
    logic [7:0]                 es_eff;
    logic [7:0]                 align_shift;
    logic [49:0]                sml_full;
    logic [49:0]                sml_shift;
    logic [49:0]                sml1_next;
    logic [50:0]                sum2_next;

    logic signed [9:0]          en;
    logic [50:0]                shv;
    logic signed [9:0]          expf;
    logic [31:0]                res3_next;

    assign en3      = !(v3_reg && out_stall);
    assign en2      = !(v2_reg && !en3);
    assign en1      = !(v1_reg && !en2);
    assign in_stall = !en1;

    // Align the smaller operand; bits shifted out are jammed into the LSB.
    always_comb
    begin
        a_inf       = (a[30:23] == fisr_pkg::EXP_ALL_ONES) && (a[22:0] == 23'd0);
        b_inf       = (b[30:23] == fisr_pkg::EXP_ALL_ONES) && (b[22:0] == 23'd0);
        a_nan       = (a[30:23] == fisr_pkg::EXP_ALL_ONES) && (a[22:0] != 23'd0);
        b_nan       = (b[30:23] == fisr_pkg::EXP_ALL_ONES) && (b[22:0] != 23'd0);
        swap        = (b[30:0] > a[30:0]);
        op_big      = swap ? b : a;
        op_sml      = swap ? a : b;
        eb_eff      = (op_big[30:23] == 8'd0) ? 8'd1 : op_big[30:23];
        es_eff      = (op_sml[30:23] == 8'd0) ? 8'd1 : op_sml[30:23];
        align_shift = eb_eff - es_eff;
        sml_full    = {(op_sml[30:23] != 8'd0), op_sml[22:0], 26'd0};
        sml_shift   = sml_full >> align_shift;
        sml1_next   = sml_shift | {49'd0, ((sml_shift << align_shift) != sml_full)};
    end

    always_comb
    begin
        if (sub1_reg)
        begin
            sum2_next = {1'b0, big1_reg} - {1'b0, sml1_reg};
        end
        else
        begin
            sum2_next = {1'b0, big1_reg} + {1'b0, sml1_reg};
        end
    end

    // Bit 50 of the sum weighs 2^(eb+1-127) before shifting.
    always_comb
    begin
        en   = $signed({2'b00, eb2_reg}) + 10'sd1 - $signed({4'b0000, lz2_reg});
        expf = 10'sd0;
        if (en > 10'sd0)
        begin
            shv  = sum2_reg << lz2_reg;
            expf = en;
        end
        else
        begin
            shv = sum2_reg << eb2_reg[5:0];
        end
        if (nan2_reg)
        begin
            res3_next = fisr_pkg::CANON_QNAN;
        end
        else if (inf2_reg)
        begin
            res3_next = {isign2_reg, fisr_pkg::EXP_ALL_ONES, 23'd0};
        end
        else if (sum2_reg == 51'd0)
        begin
            res3_next = {zsign2_reg, 31'd0};
        end
        else
        begin
            res3_next = fisr_pkg::round_pack(sign2_reg, expf, shv[50:27], shv[26],
                                             (shv[25:0] != 26'd0));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            if (en1)
            begin
                v1_reg <= in_valid;
            end
            if (en2)
            begin
                v2_reg <= v1_reg;
            end
            if (en3)
            begin
                v3_reg <= v2_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            sign1_reg  <= op_big[31];
            sub1_reg   <= a[31] ^ b[31];
            nan1_reg   <= a_nan || b_nan || (a_inf && b_inf && (a[31] != b[31]));
            inf1_reg   <= a_inf || b_inf;
            isign1_reg <= a_inf ? a[31] : b[31];
            eb1_reg    <= eb_eff;
            big1_reg   <= {(op_big[30:23] != 8'd0), op_big[22:0], 26'd0};
            sml1_reg   <= sml1_next;
            tag1_reg   <= in_tag;
        end
        if (en2)
        begin
            sign2_reg  <= sign1_reg;
            zsign2_reg <= sign1_reg && !sub1_reg;
            nan2_reg   <= nan1_reg;
            inf2_reg   <= inf1_reg;
            isign2_reg <= isign1_reg;
            eb2_reg    <= eb1_reg;
            sum2_reg   <= sum2_next;
            lz2_reg    <= fisr_pkg::lzc51(sum2_next);
            tag2_reg   <= tag1_reg;
        end
        if (en3)
        begin
            res3_reg <= res3_next;
            tag3_reg <= tag2_reg;
        end
    end

    assign out_valid = v3_reg;
    assign out_bits  = res3_reg;
    assign out_tag   = tag3_reg;

endmodule

// ===== hdl/fast_inverse_sqrt.sv =====
// ============================================================================
// fast_inverse_sqrt
// Approximate reciprocal square root of a binary32 value: integer guess
// followed by one Newton step, every operation rounded as binary32.
// ============================================================================
// The block takes one binary32 bit pattern per transfer and returns one
// result per transfer, in order. It is a 15-stage pipeline: five binary32
// units of three register stages each (x*0.5, half*y, p*y, 1.5-t, y*d),
// and a new input is taken every cycle while in_stall is low. Each stage
// holds its item while the stage after it is full and stalled, so empty
// stages keep filling while the output waits; in_stall rises only when
// every stage holds an item and out_stall is high. Every NaN result is
// returned as 0x7FC00000. The starting guess 0x5F3759DF - (x >> 1) rides
// along with each item as a tag.
module fast_inverse_sqrt
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [31:0] operand_bits,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [31:0] result_bits
);

    logic [31:0] guess;

    logic        half_valid;
    logic        half_stall;
    logic [31:0] half_bits;
    logic [31:0] half_tag;

    logic        p_valid;
    logic        p_stall;
    logic [31:0] p_bits;
    logic [31:0] p_tag;

    logic        t_valid;
    logic        t_stall;
    logic [31:0] t_bits;
    logic [31:0] t_tag;

    logic        d_valid;
    logic        d_stall;
    logic [31:0] d_bits;
    logic [31:0] d_tag;

    logic [31:0] r_tag;

    // Integer guess, wrapping modulo 2^32.
    assign guess = fisr_pkg::MAGIC_GUESS - {1'b0, operand_bits[31:1]};

    fisr_fmul u_mul_half
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .a         (operand_bits),
        .b         (fisr_pkg::FP_HALF),
        .in_tag    (guess),
        .out_valid (half_valid),
        .out_stall (half_stall),
        .out_bits  (half_bits),
        .out_tag   (half_tag)
    );

    fisr_fmul u_mul_p
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (half_valid),
        .in_stall  (half_stall),
        .a         (half_bits),
        .b         (half_tag),
        .in_tag    (half_tag),
        .out_valid (p_valid),
        .out_stall (p_stall),
        .out_bits  (p_bits),
        .out_tag   (p_tag)
    );

    fisr_fmul u_mul_t
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (p_valid),
        .in_stall  (p_stall),
        .a         (p_bits),
        .b         (p_tag),
        .in_tag    (p_tag),
        .out_valid (t_valid),
        .out_stall (t_stall),
        .out_bits  (t_bits),
        .out_tag   (t_tag)
    );

    // 1.5 - t is done as 1.5 + (-t).
    fisr_fadd u_sub_d
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (t_valid),
        .in_stall  (t_stall),
        .a         (fisr_pkg::FP_THREE_HLF),
        .b         ({~t_bits[31], t_bits[30:0]}),
        .in_tag    (t_tag),
        .out_valid (d_valid),
        .out_stall (d_stall),
        .out_bits  (d_bits),
        .out_tag   (d_tag)
    );

    fisr_fmul u_mul_r
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (d_valid),
        .in_stall  (d_stall),
        .a         (d_tag),
        .b         (d_bits),
        .in_tag    (d_tag),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_bits  (result_bits),
        .out_tag   (r_tag)
    );

    // Any NaN that leaves the block is the canonical quiet NaN.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (result_bits[30:23] == fisr_pkg::EXP_ALL_ONES)
            && (result_bits[22:0] != 23'd0))
        |-> (result_bits == fisr_pkg::CANON_QNAN))
        else $error("non-canonical NaN on result_bits");

    // Back-pressure at the input only arises from a stalled, full output.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (out_valid && out_stall))
        else $error("input stalled without output back-pressure");

    // The last unit holds its input only when its own output is blocked.
    assert property (@(posedge clk) disable iff (!rst_n)
        d_stall |-> (out_valid && out_stall))
        else $error("final multiplier stalled without cause");

    // The tag of the final stage, which carries the guess for the same item, stays stable while the result is held.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> $stable(r_tag))
        else $error("guess tag changed while result held");

endmodule

// ===== verif/fast_inverse_sqrt_checker.sv =====
`timescale 1ns / 1ps
// ============================================================================
// fast_inverse_sqrt_checker
// Watches both channels of the reciprocal square root block, predicts each
// result with a bit-exact binary32 model and compares it with what arrives.
// ============================================================================
module fast_inverse_sqrt_checker
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_stall,
    input  logic [31:0] operand_bits,
    input  logic        out_valid,
    input  logic        out_stall,
    input  logic [31:0] result_bits,
    output int          mismatches,
    output int          pending
);

    logic [31:0] expected_results[$];

    function automatic logic is_nan(input logic [31:0] v);
        return (v[30:23] == fisr_pkg::EXP_ALL_ONES) && (v[22:0] != 23'd0);
    endfunction

    function automatic logic is_inf(input logic [31:0] v);
        return (v[30:23] == fisr_pkg::EXP_ALL_ONES) && (v[22:0] == 23'd0);
    endfunction

    // Significand and exponent such that the value is sig * 2^exp.
    function automatic logic [63:0] sig_of(input logic [31:0] v);
        return (v[30:23] != 8'd0) ? {40'd0, 1'b1, v[22:0]} : {41'd0, v[22:0]};
    endfunction

    function automatic int exp_of(input logic [31:0] v);
        return (v[30:23] != 8'd0) ? int'(v[30:23]) - 150 : -149;
    endfunction

    // Rounds sign * m * 2^e to binary32, nearest even, with subnormals.
    function automatic logic [31:0] fp_round(input logic s, input logic [63:0] m,
                                             input int e);
        int          msb;
        int          sh;
        int          ex;
        int          field;
        logic [63:0] keep;
        logic        guard;
        logic        sticky;
        msb = 0;
        guard = 1'b0;
        sticky = 1'b0;
        if (m == 64'd0)
        begin
            return {s, 31'd0};
        end
        for (int i = 0; i < 64; i++)
        begin
            if (m[i])
            begin
                msb = i;
            end
        end
        sh = msb - 23;
        if (sh < -149 - e)
        begin
            sh = -149 - e;
        end
        if (sh <= 0)
        begin
            keep = m << (-sh);
        end
        else if (sh > 64)
        begin
            keep = 64'd0;
            sticky = 1'b1;
        end
        else
        begin
            keep = m >> sh;
            guard = m[sh - 1];
            sticky = |(m & ((64'd1 << (sh - 1)) - 64'd1));
        end
        keep = keep + 64'(guard & (sticky | keep[0]));
        ex = e + sh;
        if (keep[24])
        begin
            keep = keep >> 1;
            ex = ex + 1;
        end
        field = keep[23] ? ex + 150 : 0;
        if (field >= 255)
        begin
            return {s, fisr_pkg::EXP_ALL_ONES, 23'd0};
        end
        return {s, field[7:0], keep[22:0]};
    endfunction

    function automatic logic [31:0] fp_mul(input logic [31:0] a, input logic [31:0] b);
        logic s;
        s = a[31] ^ b[31];
        if (is_nan(a) || is_nan(b))
        begin
            return fisr_pkg::CANON_QNAN;
        end
        if (is_inf(a) || is_inf(b))
        begin
            if (a[30:0] == 31'd0 || b[30:0] == 31'd0)
            begin
                return fisr_pkg::CANON_QNAN;
            end
            return {s, fisr_pkg::EXP_ALL_ONES, 23'd0};
        end
        return fp_round(s, sig_of(a) * sig_of(b), exp_of(a) + exp_of(b));
    endfunction

    function automatic logic [31:0] fp_add(input logic [31:0] a, input logic [31:0] b);
        logic [31:0] tmp;
        logic [63:0] ma;
        logic [63:0] mb;
        int          d;
        if (is_nan(a) || is_nan(b))
        begin
            return fisr_pkg::CANON_QNAN;
        end
        if (is_inf(a) && is_inf(b) && a[31] != b[31])
        begin
            return fisr_pkg::CANON_QNAN;
        end
        if (is_inf(a))
        begin
            return a;
        end
        if (is_inf(b))
        begin
            return b;
        end
        if (a[30:0] == 31'd0 && b[30:0] == 31'd0)
        begin
            return {a[31] & b[31], 31'd0};
        end
        if (exp_of(a) < exp_of(b))
        begin
            tmp = a;
            a = b;
            b = tmp;
        end
        // Align the smaller operand with 26 spare bits and a sticky bit.
        d = exp_of(a) - exp_of(b);
        ma = sig_of(a) << 26;
        mb = sig_of(b) << 26;
        if (d >= 60)
        begin
            mb = (mb != 64'd0) ? 64'd1 : 64'd0;
        end
        else if (d > 0)
        begin
            mb = (mb >> d) | 64'(|(mb & ((64'd1 << d) - 64'd1)));
        end
        if (a[31] == b[31])
        begin
            return fp_round(a[31], ma + mb, exp_of(a) - 26);
        end
        // Equal magnitudes of opposite sign cancel to positive zero.
        if (ma == mb)
        begin
            return 32'd0;
        end
        if (ma > mb)
        begin
            return fp_round(a[31], ma - mb, exp_of(a) - 26);
        end
        return fp_round(b[31], mb - ma, exp_of(a) - 26);
    endfunction

    // Integer guess, then one Newton step with each operation rounded.
    function automatic logic [31:0] rsqrt_estimate(input logic [31:0] x);
        logic [31:0] guess;
        logic [31:0] half;
        logic [31:0] prod;
        logic [31:0] t;
        logic [31:0] diff;
        logic [31:0] r;
        guess = fisr_pkg::MAGIC_GUESS - (x >> 1);
        half = fp_mul(x, fisr_pkg::FP_HALF);
        prod = fp_mul(half, guess);
        t = fp_mul(prod, guess);
        diff = fp_add(fisr_pkg::FP_THREE_HLF, {~t[31], t[30:0]});
        r = fp_mul(guess, diff);
        return is_nan(r) ? fisr_pkg::CANON_QNAN : r;
    endfunction

    assign pending = expected_results.size();

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mismatches <= 0;
            expected_results.delete();
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                expected_results.push_back(rsqrt_estimate(operand_bits));
            end
            if (out_valid && !out_stall)
            begin
                if (expected_results.size() == 0)
                begin
                    if (mismatches < 10)
                    begin
                        $display("unexpected result %h", result_bits);
                    end
                    mismatches <= mismatches + 1;
                end
                else
                begin
                    if (result_bits !== expected_results[0])
                    begin
                        if (mismatches < 10)
                        begin
                            $display("result_bits mismatch: expected %h, got %h",
                                     expected_results[0], result_bits);
                        end
                        mismatches <= mismatches + 1;
                    end
                    void'(expected_results.pop_front());
                end
            end
        end
    end

endmodule

// ===== verif/fast_inverse_sqrt_test.sv =====
`timescale 1ns / 1ps
// ============================================================================
// fast_inverse_sqrt_test
// Drives binary32 operands into the reciprocal square root pipeline with
// random gaps and output stalls; the checker predicts and compares results.
// ============================================================================
module fast_inverse_sqrt_test;
    localparam int RANDOM_ITEMS   = 830;
    localparam int CALM_ITEMS     = 100;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 40;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [31:0] operand_bits;
    logic        out_valid;
    logic        out_stall;
    logic [31:0] result_bits;
    int          mismatches;
    int          pending;

    // Idling is switched off for the final stretch of the run.
    logic        calm;
    int          stall_left;
    int          idle_cycles;

    // A handful of operands that hit zeros, infinities, NaNs, subnormals,
    // the largest finite value and a few ordinary numbers of both signs.
    logic [31:0] directed_operands[] = '{
        32'h00000000, 32'h80000000, 32'h7F800000, 32'hFF800000,
        32'h7FC00000, 32'h7F800001, 32'hFFFFFFFF, 32'h7FBFFFFF,
        32'h00000001, 32'h007FFFFF, 32'h00800000, 32'h80000001,
        32'h7F7FFFFF, 32'hFF7FFFFF, 32'h3F800000, 32'h40800000,
        32'h3E800000, 32'hBF800000, 32'h5F3759DF, 32'hBE3759DF,
        32'h3F7FFFFF, 32'h4B000001, 32'h00400000, 32'h55555555,
        32'hAAAAAAAA
    };

    fast_inverse_sqrt DUT
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .operand_bits (operand_bits),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .result_bits  (result_bits)
    );

    fast_inverse_sqrt_checker checker_inst
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .operand_bits (operand_bits),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .result_bits  (result_bits),
        .mismatches   (mismatches),
        .pending      (pending)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // The output side stalls in bursts, then runs free for a random while,
    // so stalls land on every stage of the pipeline.
    always @(negedge clk)
    begin
        if (stall_left > 0)
        begin
            stall_left <= stall_left - 1;
            out_stall <= 1'b1;
        end
        else if (!calm && $urandom_range(0, 9) == 0)
        begin
            stall_left <= $urandom_range(0, 5);
            out_stall <= 1'b1;
        end
        else
        begin
            out_stall <= 1'b0;
        end
    end

    // The watchdog counts cycles in which neither channel completes a transfer.
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
        begin
            idle_cycles <= 0;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    // Presents one operand and holds it until the transfer happens. An
    // optional gap with in_valid low comes before it, outside calm.
    task automatic send_operand(input logic [31:0] value);
        int gap;
        gap = 0;
        if (!calm && $urandom_range(0, 5) == 0)
        begin
            gap = $urandom_range(1, 6);
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        operand_bits <= value;
        @(posedge clk);
        while (in_stall)
        begin
            @(posedge clk);
        end
        @(negedge clk);
    endtask

    // Random operands: mostly positive normals where the estimate matters,
    // plus raw patterns, subnormals, values near the exponent limits and
    // special encodings with random payloads.
    function automatic logic [31:0] random_operand();
        logic [31:0] v;
        v = $urandom();
        case ($urandom_range(0, 9))
            0, 1, 2:
            begin
                v[31] = 1'b0;
            end
            3:
            begin
                v[30:23] = 8'd0;
            end
            4:
            begin
                v[30:23] = $urandom_range(0, 1) ? 8'd1 : 8'd254;
            end
            5:
            begin
                v[30:23] = 8'hFF;
                if ($urandom_range(0, 1) == 0)
                begin
                    v[22:0] = 23'd0;
                end
            end
            6:
            begin
                v[30:0] = $urandom_range(0, 1) ? 31'd0 : 31'($urandom_range(1, 3));
            end
            default:
            begin
            end
        endcase
        return v;
    endfunction

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        operand_bits = 32'd0;
        out_stall = 1'b0;
        stall_left = 0;
        idle_cycles = 0;
        calm = 1'b0;
        repeat (6) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        foreach (directed_operands[i])
        begin
            send_operand(directed_operands[i]);
        end
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n == RANDOM_ITEMS - CALM_ITEMS)
            begin
                calm = 1'b1;
            end
            send_operand(random_operand());
        end
        in_valid <= 1'b0;

        // Let the pipeline empty, then wait out DRAIN_CYCLES so that any
        // stray result can still show up.
        while (pending != 0)
        begin
            @(negedge clk);
        end
        repeat (DRAIN_CYCLES) @(negedge clk);

        if (mismatches == 0)
        begin
            $display("tb: success");
        end
        else
        begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
hdl/fisr_pkg.sv
hdl/fisr_fmul.sv
hdl/fisr_fadd.sv
hdl/fast_inverse_sqrt.sv
verif/fast_inverse_sqrt_checker.sv
verif/fast_inverse_sqrt_test.sv
